/* design/scpa_pkg.sv */
// Shared types and constants for the size-class page allocator.
package scpa_pkg;

    localparam int HEAP_PAGES   = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int SIZE_CLASSES = 9;
    localparam int SMALL_LIMIT  = 2048;
    localparam int HDR_BYTES    = 8;
    localparam int BPP          = PAGE_BYTES / 8;

    localparam int PG_W   = $clog2(HEAP_PAGES);
    localparam int PTR_W  = PG_W + 1;
    localparam int BLK_W  = $clog2(BPP);
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int CLS_W  = 4;
    localparam int CNT_W  = 10;
    localparam int NP_W   = 9;
    localparam int LINK_W = 10;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(HEAP_PAGES);

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OOM     = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // per-page metadata word
    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  head;
        logic [PTR_W-1:0]  nxt;
        logic [PTR_W-1:0]  clen;
        logic [PTR_W-1:0]  cnext;
    } meta_t;

    localparam int META_W = $bits(meta_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SM_RD,
        S_SM_CHK,
        S_SM_NEW,
        S_SM_REC,
        S_INIT,
        S_INIT_META,
        S_POP_RD,
        S_POP_WR,
        S_BG_RD,
        S_BG_CHK,
        S_BG_TOP,
        S_BG_TAIL_RD,
        S_BG_TAIL_WR,
        S_BG_PREV_RD,
        S_BG_PREV_WR,
        S_FR_CHK,
        S_FR_CHUNK,
        S_UL_RD,
        S_UL_CHK,
        S_FR_REL,
        S_DONE
    } state_t;

endpackage

/* design/size_class_page_allocator.sv */
// Top level of the size-class page allocator.
// Usage:
//   s_axis carries one request per item: tuser is the action (0 allocate, 1 free),
//   tdata holds request_bytes and free_address. m_axis returns one result per item
//   with block_address and status. cfg_valid/cfg_data write heap_limit_pages;
//   write it only while no request is in flight.
// Timing: one item is worked at a time; s_axis_tready is high only when idle.
//   Each step of a list walk, one per page visited in the class list, chunk
//   list or unlink walk (up to 64 pages each), is one read of the page
//   metadata RAM plus one check. A small allocate that opens a page also
//   writes the block free list of that page, one link per cycle: 512 >> class
//   links (2 to 512).
// Reset clears all lists, the heap top and the limit (back to 64); metadata
//   and block links need no clearing pass.
// Results sit in an output register: a stall on m_axis holds it, and the next
//   item is accepted and worked meanwhile, waiting only at its own result.
module size_class_page_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_bytes[19:0], free_address[37:20], zero pad
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // block_address[17:0], status[19:18], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data        // heap_limit_pages
);

    import scpa_pkg::*;

    state_t state_reg, state_next;

    logic [6:0]       limit_cfg_reg, limit_cfg_next;
    logic [PTR_W-1:0] class_head_reg [SIZE_CLASSES];
    logic [PTR_W-1:0] class_head_next [SIZE_CLASSES];
    logic [PTR_W-1:0] recycled_reg, recycled_next;
    logic [PTR_W-1:0] chunk_head_reg, chunk_head_next;
    logic [PTR_W-1:0] top_reg, top_next;
    logic [HEAP_PAGES-1:0] in_class_reg, in_class_next;
    logic [HEAP_PAGES-1:0] is_chunk_reg, is_chunk_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [23:0]      m_tdata_reg, m_tdata_next;

    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0] prev_reg, prev_next;
    logic [PTR_W-1:0] steps_reg, steps_next;
    logic [PTR_W-1:0] p_reg, p_next;
    logic [CLS_W-1:0] cls_reg, cls_next;
    logic [NP_W-1:0]  np_reg, np_next;
    logic [BLK_W-1:0] idx_reg, idx_next;
    meta_t            meta_reg, meta_next;
    logic [17:0]      fa_reg, fa_next;
    logic [17:0]      addr_reg, addr_next;
    logic [1:0]       st_reg, st_next;

    // memory ports
    logic                  meta_we;
    logic [PG_W-1:0]       meta_waddr, meta_raddr;
    meta_t                 meta_wdata, mrd;
    logic [META_W-1:0]     meta_rdata_raw;
    logic                  link_we;
    logic [PG_W+BLK_W-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0]     link_wdata, link_rdata;

    scpa_ram #(.WIDTH(META_W), .DEPTH(HEAP_PAGES)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata_raw)
    );

    scpa_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_PAGES * BPP)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign mrd = meta_t'(meta_rdata_raw);

    // input decode
    logic [19:0]      in_req;
    logic [17:0]      in_fa;
    logic [PG_W-1:0]  in_pg;
    logic             in_small;
    logic [CLS_W-1:0] in_cls;
    logic [20:0]      in_np_sum;
    logic             accept;

    assign in_req    = s_axis_tdata[19:0];
    assign in_fa     = s_axis_tdata[37:20];
    assign in_pg     = in_fa[17:OFF_W];
    assign in_small  = in_req < 20'(SMALL_LIMIT);
    assign in_np_sum = {1'b0, in_req} + 21'(HDR_BYTES + PAGE_BYTES - 1);
    assign accept    = s_axis_tvalid && (state_reg == S_IDLE);

    always_comb
    begin
        in_cls = '0;
        for (int c = SIZE_CLASSES - 1; c >= 0; c--)
        begin
            if ({1'b0, in_req} <= (21'd8 << c))
            begin
                in_cls = CLS_W'(c);
            end
        end
    end

    // datapath helpers
    logic [6:0]        limit;
    logic [CNT_W-1:0]  n_cls;
    logic              clen_gt, clen_eq;
    logic [PTR_W-1:0]  newlen, tail_pg;
    logic [OFF_W-1:0]  fr_off, fr_mask;
    logic [4:0]        fr_sh;
    logic              fr_bad, fr_full;
    logic [BLK_W-1:0]  fr_b;
    logic [CNT_W-1:0]  fr_cnt;
    logic              ul_hit;
    logic [20:0]       pop_sh;
    logic [9:0]        top_sum;

    assign limit   = (limit_cfg_reg > 7'(HEAP_PAGES)) ? 7'(HEAP_PAGES) : limit_cfg_reg;
    assign n_cls   = CNT_W'(BPP) >> cls_reg;
    assign clen_gt = {2'b00, mrd.clen} > np_reg;
    assign clen_eq = {2'b00, mrd.clen} == np_reg;
    assign newlen  = mrd.clen - np_reg[PTR_W-1:0];
    assign tail_pg = cur_reg + newlen;
    assign fr_off  = fa_reg[OFF_W-1:0];
    assign fr_sh   = {1'b0, mrd.cls} + 5'd3;
    assign fr_mask = (OFF_W'(8) << mrd.cls) - OFF_W'(1);
    assign fr_bad  = (mrd.cls >= CLS_W'(SIZE_CLASSES)) || ((fr_off & fr_mask) != '0);
    assign fr_b    = BLK_W'(fr_off >> fr_sh);
    assign fr_cnt  = mrd.cnt + CNT_W'(1);
    assign fr_full = fr_cnt >= (CNT_W'(BPP) >> mrd.cls);
    assign ul_hit  = mrd.nxt == p_reg;
    assign pop_sh  = {12'd0, meta_reg.head[BLK_W-1:0]} << ({1'b0, cls_reg} + 5'd3);
    assign top_sum = {3'b000, top_reg} + {1'b0, np_reg};

    // next state and register updates
    always_comb
    begin
        state_next      = state_reg;
        limit_cfg_next  = limit_cfg_reg;
        class_head_next = class_head_reg;
        recycled_next   = recycled_reg;
        chunk_head_next = chunk_head_reg;
        top_next        = top_reg;
        in_class_next   = in_class_reg;
        is_chunk_next   = is_chunk_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        m_tdata_next    = m_tdata_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        p_next          = p_reg;
        cls_next        = cls_reg;
        np_next         = np_reg;
        idx_next        = idx_reg;
        meta_next       = meta_reg;
        fa_next         = fa_reg;
        addr_next       = addr_reg;
        st_next         = st_reg;

        if (cfg_valid)
        begin
            limit_cfg_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fa_next    = in_fa;
                    cls_next   = in_cls;
                    np_next    = in_np_sum[20:OFF_W];
                    steps_next = '0;
                    prev_next  = NULL_PTR;
                    addr_next  = '0;
                    st_next    = STATUS_OK;
                    if (s_axis_tuser == ACT_FREE)
                    begin
                        p_next = {1'b0, in_pg};
                        if (in_class_reg[in_pg])
                        begin
                            state_next = S_FR_CHK;
                        end
                        else if (in_fa[OFF_W-1:0] == OFF_W'(HDR_BYTES) && is_chunk_reg[in_pg])
                        begin
                            is_chunk_next[in_pg] = 1'b0;
                            state_next = S_FR_CHUNK;
                        end
                        else
                        begin
                            st_next    = STATUS_INVALID;
                            state_next = S_DONE;
                        end
                    end
                    else if (in_small)
                    begin
                        cur_next   = class_head_reg[in_cls];
                        state_next = S_SM_RD;
                    end
                    else
                    begin
                        cur_next   = chunk_head_reg;
                        state_next = S_BG_RD;
                    end
                end
            end

            S_SM_RD:
            begin
                if (cur_reg >= NULL_PTR || steps_reg == PTR_W'(HEAP_PAGES))
                begin
                    state_next = S_SM_NEW;
                end
                else
                begin
                    state_next = S_SM_CHK;
                end
            end

            S_SM_CHK:
            begin
                if (mrd.cnt != '0)
                begin
                    p_next     = cur_reg;
                    meta_next  = mrd;
                    state_next = S_POP_RD;
                end
                else
                begin
                    cur_next   = mrd.nxt;
                    steps_next = steps_reg + PTR_W'(1);
                    state_next = S_SM_RD;
                end
            end

            S_SM_NEW:
            begin
                idx_next = '0;
                if (recycled_reg < NULL_PTR)
                begin
                    p_next     = recycled_reg;
                    state_next = S_SM_REC;
                end
                else if (top_reg < limit)
                begin
                    p_next     = top_reg;
                    top_next   = top_reg + PTR_W'(1);
                    state_next = S_INIT;
                end
                else
                begin
                    st_next    = STATUS_OOM;
                    state_next = S_DONE;
                end
            end

            S_SM_REC:
            begin
                recycled_next = mrd.nxt;
                meta_next     = mrd;
                state_next    = S_INIT;
            end

            S_INIT:
            begin
                idx_next = idx_reg + BLK_W'(1);
                if (idx_reg == BLK_W'(n_cls - CNT_W'(1)))
                begin
                    state_next = S_INIT_META;
                end
            end

            S_INIT_META:
            begin
                meta_next.cls  = cls_reg;
                meta_next.cnt  = n_cls;
                meta_next.head = n_cls - CNT_W'(1);
                meta_next.nxt  = class_head_reg[cls_reg];
                class_head_next[cls_reg] = p_reg;
                in_class_next[p_reg[PG_W-1:0]] = 1'b1;
                state_next = S_POP_RD;
            end

            S_POP_RD:
            begin
                state_next = S_POP_WR;
            end

            S_POP_WR:
            begin
                addr_next  = {p_reg[PG_W-1:0], pop_sh[OFF_W-1:0]};
                state_next = S_DONE;
            end

            S_BG_RD:
            begin
                if (cur_reg >= NULL_PTR || steps_reg == PTR_W'(HEAP_PAGES))
                begin
                    state_next = S_BG_TOP;
                end
                else
                begin
                    state_next = S_BG_CHK;
                end
            end

            S_BG_CHK:
            begin
                meta_next = mrd;
                if (clen_gt)
                begin
                    if (tail_pg >= NULL_PTR)
                    begin
                        st_next    = STATUS_OOM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        p_next     = tail_pg;
                        state_next = S_BG_TAIL_RD;
                    end
                end
                else if (clen_eq)
                begin
                    is_chunk_next[cur_reg[PG_W-1:0]] = 1'b1;
                    addr_next = {cur_reg[PG_W-1:0], OFF_W'(HDR_BYTES)};
                    if (prev_reg < NULL_PTR)
                    begin
                        state_next = S_BG_PREV_RD;
                    end
                    else
                    begin
                        chunk_head_next = mrd.cnext;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = mrd.cnext;
                    steps_next = steps_reg + PTR_W'(1);
                    state_next = S_BG_RD;
                end
            end

            S_BG_TOP:
            begin
                if (top_sum > {3'b000, limit})
                begin
                    st_next    = STATUS_OOM;
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = top_reg;
                    top_next   = top_sum[PTR_W-1:0];
                    state_next = S_BG_TAIL_RD;
                end
            end

            S_BG_TAIL_RD:
            begin
                state_next = S_BG_TAIL_WR;
            end

            S_BG_TAIL_WR:
            begin
                is_chunk_next[p_reg[PG_W-1:0]] = 1'b1;
                addr_next  = {p_reg[PG_W-1:0], OFF_W'(HDR_BYTES)};
                state_next = S_DONE;
            end

            S_BG_PREV_RD:
            begin
                state_next = S_BG_PREV_WR;
            end

            S_BG_PREV_WR:
            begin
                state_next = S_DONE;
            end

            S_FR_CHK:
            begin
                if (fr_bad)
                begin
                    st_next    = STATUS_INVALID;
                    state_next = S_DONE;
                end
                else if (fr_full)
                begin
                    meta_next      = mrd;
                    meta_next.head = {1'b0, fr_b};
                    meta_next.cnt  = fr_cnt;
                    cls_next       = mrd.cls;
                    if (class_head_reg[mrd.cls] == p_reg)
                    begin
                        class_head_next[mrd.cls] = mrd.nxt;
                        state_next = S_FR_REL;
                    end
                    else
                    begin
                        cur_next   = class_head_reg[mrd.cls];
                        state_next = S_UL_RD;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_UL_RD:
            begin
                if (cur_reg >= NULL_PTR || steps_reg == PTR_W'(HEAP_PAGES))
                begin
                    state_next = S_FR_REL;
                end
                else
                begin
                    state_next = S_UL_CHK;
                end
            end

            S_UL_CHK:
            begin
                if (ul_hit)
                begin
                    state_next = S_FR_REL;
                end
                else
                begin
                    cur_next   = mrd.nxt;
                    steps_next = steps_reg + PTR_W'(1);
                    state_next = S_UL_RD;
                end
            end

            S_FR_REL:
            begin
                in_class_next[p_reg[PG_W-1:0]] = 1'b0;
                recycled_next = p_reg;
                state_next    = S_DONE;
            end

            S_FR_CHUNK:
            begin
                chunk_head_next = p_reg;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, st_reg, addr_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory strobes and handshake outputs
    always_comb
    begin
        meta_raddr = cur_reg[PG_W-1:0];
        meta_we    = 1'b0;
        meta_waddr = p_reg[PG_W-1:0];
        meta_wdata = mrd;
        link_raddr = {p_reg[PG_W-1:0], meta_reg.head[BLK_W-1:0]};
        link_we    = 1'b0;
        link_waddr = {p_reg[PG_W-1:0], idx_reg};
        link_wdata = (idx_reg == '0) ? '0 : LINK_W'(idx_reg - BLK_W'(1));
        s_axis_tready = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                meta_raddr = in_pg;
            end

            S_SM_NEW:
            begin
                meta_raddr = recycled_reg[PG_W-1:0];
            end

            S_INIT:
            begin
                link_we = 1'b1;
            end

            S_INIT_META:
            begin
                meta_we         = 1'b1;
                meta_wdata      = meta_reg;
                meta_wdata.cls  = cls_reg;
                meta_wdata.cnt  = n_cls;
                meta_wdata.head = n_cls - CNT_W'(1);
                meta_wdata.nxt  = class_head_reg[cls_reg];
            end

            S_POP_WR:
            begin
                meta_we         = 1'b1;
                meta_wdata      = meta_reg;
                meta_wdata.head = link_rdata;
                meta_wdata.cnt  = meta_reg.cnt - CNT_W'(1);
            end

            S_BG_CHK:
            begin
                meta_we         = clen_gt;
                meta_waddr      = cur_reg[PG_W-1:0];
                meta_wdata.clen = newlen;
            end

            S_BG_TAIL_RD:
            begin
                meta_raddr = p_reg[PG_W-1:0];
            end

            S_BG_TAIL_WR:
            begin
                meta_we         = 1'b1;
                meta_wdata.clen = np_reg[PTR_W-1:0];
            end

            S_BG_PREV_RD:
            begin
                meta_raddr = prev_reg[PG_W-1:0];
            end

            S_BG_PREV_WR:
            begin
                meta_we          = 1'b1;
                meta_waddr       = prev_reg[PG_W-1:0];
                meta_wdata.cnext = meta_reg.cnext;
            end

            S_FR_CHK:
            begin
                link_we         = !fr_bad;
                link_waddr      = {p_reg[PG_W-1:0], fr_b};
                link_wdata      = mrd.head;
                meta_we         = !fr_bad && !fr_full;
                meta_wdata.head = {1'b0, fr_b};
                meta_wdata.cnt  = fr_cnt;
            end

            S_UL_CHK:
            begin
                meta_we        = ul_hit;
                meta_waddr     = cur_reg[PG_W-1:0];
                meta_wdata.nxt = meta_reg.nxt;
            end

            S_FR_REL:
            begin
                meta_we        = 1'b1;
                meta_wdata     = meta_reg;
                meta_wdata.nxt = recycled_reg;
            end

            S_FR_CHUNK:
            begin
                meta_we          = 1'b1;
                meta_wdata.cnext = chunk_head_reg;
            end

            default:
            begin
                meta_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_cfg_reg  <= 7'(HEAP_PAGES);
            for (int i = 0; i < SIZE_CLASSES; i++)
            begin
                class_head_reg[i] <= NULL_PTR;
            end
            recycled_reg   <= NULL_PTR;
            chunk_head_reg <= NULL_PTR;
            top_reg        <= '0;
            in_class_reg   <= '0;
            is_chunk_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_cfg_reg  <= limit_cfg_next;
            class_head_reg <= class_head_next;
            recycled_reg   <= recycled_next;
            chunk_head_reg <= chunk_head_next;
            top_reg        <= top_next;
            in_class_reg   <= in_class_next;
            is_chunk_reg   <= is_chunk_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        steps_reg   <= steps_next;
        p_reg       <= p_next;
        cls_reg     <= cls_next;
        np_reg      <= np_next;
        idx_reg     <= idx_next;
        meta_reg    <= meta_next;
        fa_reg      <= fa_next;
        addr_reg    <= addr_next;
        st_reg      <= st_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign cfg_ready     = 1'b1;

endmodule

/* design/scpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/scpa_checker.sv */
// Port-level checks for the size-class page allocator, bound to the top level.
module scpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    import scpa_pkg::*;

    logic [1:0]  status;
    logic [17:0] address;

    assign status  = m_axis_tdata[19:18];
    assign address = m_axis_tdata[17:0];

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status == STATUS_OK || status == STATUS_OOM
                           || status == STATUS_INVALID))
        else $error("unknown status code");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status != STATUS_OK |-> address == '0)
        else $error("failed item carries an address");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

endmodule

bind size_class_page_allocator scpa_checker u_scpa_checker (.*);

/* tb/size_class_page_allocator_test.sv */
// Self-checking testbench for the size-class page allocator: stream stimulus, predictor, checker.
module size_class_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import scpa_pkg::*;

    typedef struct {
        bit act;
        int req;
        int fa;
    } request_t;

    typedef struct {
        bit act;
        int addr;
        int st;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];
    int       live_blocks[$];
    int       errors = 0;
    bit       in_acc = 1'b0, out_acc = 1'b0;
    int       send_gap = 0, recv_gap = 0, long_hold = 0;
    bit       no_idle = 1'b0, hold_req = 1'b0, hold_done = 1'b0;

    // predictor state
    int pg_class[HEAP_PAGES], pg_cnt[HEAP_PAGES], pg_head[HEAP_PAGES], pg_next[HEAP_PAGES];
    bit pg_chunk[HEAP_PAGES], pg_inlist[HEAP_PAGES];
    int chunk_len[HEAP_PAGES], chunk_nxt[HEAP_PAGES];
    int cls_head[SIZE_CLASSES];
    int blink[HEAP_PAGES*BPP];
    int recycled, heap_top, chunk_first, heap_limit;

    size_class_page_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int grow_limit();
        return heap_limit > HEAP_PAGES ? HEAP_PAGES : heap_limit;
    endfunction

    function automatic int take_small(int c, output int addr);
        int size, p, steps, n, b;
        size = 8 << c;
        p = cls_head[c];
        steps = 0;
        while (p < HEAP_PAGES && steps < HEAP_PAGES)
        begin
            if (pg_cnt[p] > 0)
                break;
            p = pg_next[p];
            steps++;
        end
        if (p >= HEAP_PAGES || steps >= HEAP_PAGES)
        begin
            n = PAGE_BYTES / size;
            if (recycled < HEAP_PAGES)
            begin
                p = recycled;
                recycled = pg_next[p];
            end
            else if (heap_top < grow_limit())
            begin
                p = heap_top;
                heap_top++;
            end
            else
                return STATUS_OOM;
            pg_class[p] = c;
            pg_inlist[p] = 1'b1;
            pg_cnt[p] = n;
            pg_head[p] = n - 1;
            blink[p*BPP] = 0;
            for (int i = 1; i < n; i++)
                blink[p*BPP + i] = i - 1;
            pg_next[p] = cls_head[c];
            cls_head[c] = p;
        end
        b = pg_head[p] % BPP;
        pg_head[p] = blink[p*BPP + b];
        pg_cnt[p]--;
        addr = p * PAGE_BYTES + b * size;
        return STATUS_OK;
    endfunction

    function automatic int take_pages(int req, output int addr);
        int npages, cur, prev, t;
        npages = (req + HDR_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
        cur = chunk_first;
        prev = HEAP_PAGES;
        for (int steps = 0; cur < HEAP_PAGES && steps < HEAP_PAGES; steps++)
        begin
            if (chunk_len[cur] > npages)
            begin
                // split: hand out the tail pages
                chunk_len[cur] -= npages;
                t = cur + chunk_len[cur];
                if (t >= HEAP_PAGES)
                    return STATUS_OOM;
                chunk_len[t] = npages;
                pg_chunk[t] = 1'b1;
                addr = t * PAGE_BYTES + HDR_BYTES;
                return STATUS_OK;
            end
            if (chunk_len[cur] == npages)
            begin
                if (prev < HEAP_PAGES)
                    chunk_nxt[prev] = chunk_nxt[cur];
                else
                    chunk_first = chunk_nxt[cur];
                pg_chunk[cur] = 1'b1;
                addr = cur * PAGE_BYTES + HDR_BYTES;
                return STATUS_OK;
            end
            prev = cur;
            cur = chunk_nxt[cur];
        end
        if (heap_top + npages > grow_limit())
            return STATUS_OOM;
        cur = heap_top;
        heap_top += npages;
        chunk_len[cur] = npages;
        pg_chunk[cur] = 1'b1;
        addr = cur * PAGE_BYTES + HDR_BYTES;
        return STATUS_OK;
    endfunction

    function automatic int release_block(int a);
        int p, off, c, size, b, cur;
        p = a / PAGE_BYTES;
        off = a % PAGE_BYTES;
        if (p >= HEAP_PAGES)
            return STATUS_INVALID;
        if (pg_inlist[p])
        begin
            c = pg_class[p];
            if (c >= SIZE_CLASSES)
                return STATUS_INVALID;
            size = 8 << c;
            if (off % size != 0)
                return STATUS_INVALID;
            b = off / size;
            blink[p*BPP + b] = pg_head[p];
            pg_head[p] = b;
            pg_cnt[p]++;
            if (pg_cnt[p] >= PAGE_BYTES / size)
            begin
                // page wholly free: unlink from its class, push to recycled
                if (cls_head[c] == p)
                    cls_head[c] = pg_next[p];
                else
                begin
                    cur = cls_head[c];
                    for (int s = 0; cur < HEAP_PAGES && s < HEAP_PAGES; s++)
                    begin
                        if (pg_next[cur] == p)
                        begin
                            pg_next[cur] = pg_next[p];
                            break;
                        end
                        cur = pg_next[cur];
                    end
                end
                pg_inlist[p] = 1'b0;
                pg_next[p] = recycled;
                recycled = p;
            end
            return STATUS_OK;
        end
        if (off == HDR_BYTES && pg_chunk[p])
        begin
            pg_chunk[p] = 1'b0;
            chunk_nxt[p] = chunk_first;
            chunk_first = p;
            return STATUS_OK;
        end
        return STATUS_INVALID;
    endfunction

    function automatic outcome_t predict_outcome(request_t r);
        outcome_t o;
        int c;
        o.act = r.act;
        o.addr = 0;
        if (r.act == ACT_ALLOC)
        begin
            c = SIZE_CLASSES;
            if (r.req < SMALL_LIMIT)
                for (int i = SIZE_CLASSES - 1; i >= 0; i--)
                    if (r.req <= (8 << i))
                        c = i;
            if (c < SIZE_CLASSES)
                o.st = take_small(c, o.addr);
            else
                o.st = take_pages(r.req, o.addr);
            if (o.st != STATUS_OK)
                o.addr = 0;
        end
        else
            o.st = release_block(r.fa);
        return o;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // prediction on accept, and checking of each result against it
    always @(posedge clk)
    begin
        in_acc <= s_axis_tvalid && s_axis_tready;
        out_acc <= m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            request_t r;
            r.act = s_axis_tuser;
            r.req = s_axis_tdata[19:0];
            r.fa = s_axis_tdata[37:20];
            expected_outcomes.push_back(predict_outcome(r));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_outcomes.size() == 0)
                report("unexpected item", m_axis_tdata[17:0], -1);
            else
            begin
                outcome_t e;
                e = expected_outcomes.pop_front();
                if (m_axis_tdata[17:0] != e.addr)
                    report("block_address", m_axis_tdata[17:0], e.addr);
                if (m_axis_tdata[19:18] != e.st)
                    report("status", m_axis_tdata[19:18], e.st);
                if (e.act == ACT_ALLOC && e.st == STATUS_OK)
                    live_blocks.push_back(e.addr);
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_acc)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid = 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                request_t r;
                r = pending_reqs.pop_front();
                s_axis_tuser = r.act;
                s_axis_tdata = {2'b00, r.fa[17:0], r.req[19:0]};
                s_axis_tvalid = 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            else
                s_axis_tvalid = 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_acc)
                recv_gap = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                long_hold = 400;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                m_axis_tready = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || expected_outcomes.size() != 0 || s_axis_tvalid
               || long_hold != 0);
    endtask

    task automatic write_limit(int v);
        @(negedge clk);
        cfg_data = v[6:0];
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        heap_limit = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic push_alloc(int req);
        request_t r;
        r.act = ACT_ALLOC;
        r.req = req;
        r.fa = $urandom_range(0, 262143);
        pending_reqs.push_back(r);
    endtask

    task automatic push_free(int a);
        request_t r;
        r.act = ACT_FREE;
        r.req = $urandom_range(0, 1048575);
        r.fa = a;
        pending_reqs.push_back(r);
    endtask

    function automatic int pick_size();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return $urandom_range(0, 2047) >> $urandom_range(0, 10);
        if (k < 95)
            return $urandom_range(2048, 24000);
        return $urandom_range(0, 1048575);
    endfunction

    task automatic random_batch(int n);
        int k, i, a;
        for (int j = 0; j < n; j++)
        begin
            k = $urandom_range(0, 99);
            if (k < 50 || live_blocks.size() == 0)
                push_alloc(pick_size());
            else if (k < 88)
            begin
                i = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[i];
                live_blocks.delete(i);
                push_free(a);
            end
            else if (k < 94)
            begin
                // broken: misaligned or repeated free of a live block
                a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                push_free((a + $urandom_range(0, 7)) & 18'h3ffff);
            end
            else
                push_free($urandom_range(0, 262143));
        end
    endtask

    initial
    begin
        int limits[6];
        int a;
        limits = '{64, 1, 127, 0, 20, 64};
        heap_limit = 64;
        recycled = HEAP_PAGES;
        chunk_first = HEAP_PAGES;
        heap_top = 0;
        foreach (cls_head[i])
            cls_head[i] = HEAP_PAGES;
        foreach (pg_inlist[i])
        begin
            pg_inlist[i] = 1'b0;
            pg_chunk[i] = 1'b0;
            pg_class[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: size edges and both paths
        push_alloc(0);
        push_alloc(1);
        push_alloc(8);
        push_alloc(9);
        push_alloc(2047);
        push_alloc(2048);
        push_alloc(4088);
        push_alloc(4089);
        push_alloc(1048575);
        push_alloc(1024);
        drain();
        a = live_blocks[0];
        push_free(a + 4);               // misaligned in a class page
        push_free(a);
        push_free(a);                   // repeated small free
        push_free(live_blocks[5]);      // chunk
        push_free(live_blocks[5]);      // second free of same chunk
        push_free(262143);
        push_free(0);
        push_free(HDR_BYTES);
        for (int i = 1; i < live_blocks.size(); i++)
            if (i != 5)
                push_free(live_blocks[i]);
        live_blocks.delete();
        push_alloc(2048);               // reuses freed chunk
        drain();

        foreach (limits[ph])
        begin
            write_limit(limits[ph]);
            no_idle = (ph == 2);
            for (int b = 0; b < 4; b++)
            begin
                if (ph == 1 && b == 1)
                    hold_req = 1'b1;
                random_batch(26);
                drain();
            end
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
